/* hdl/gzhp_pkg.sv */
// Shared types and constants for the gzip member header parser.
// Holds the byte and result request structs and the header byte codes.
// No dependencies.
`default_nettype none

package gzhp_pkg;

	// Width of the running header length counter
	localparam int unsigned LENGTH_BITS = 20;
	localparam int unsigned HDR_LEN_W   = 20;
	localparam int unsigned FIELD_W     = 16;
	localparam int unsigned FLAG_W      = 5;

	// Fixed header bytes
	localparam logic [7:0] MAGIC_ID1   = 8'h1F;
	localparam logic [7:0] MAGIC_ID2   = 8'h8B;
	localparam logic [7:0] METHOD_DEFL = 8'h08;
	localparam logic [7:0] FLG_RSVD    = 8'hE0;

	// Flag bits (low five bits of FLG)
	localparam int unsigned FLG_HCRC_BIT    = 1;
	localparam int unsigned FLG_EXTRA_BIT   = 2;
	localparam int unsigned FLG_NAME_BIT    = 3;
	localparam int unsigned FLG_COMMENT_BIT = 4;

	// Bytes of the fixed part that follow FLG (MTIME, XFL, OS)
	localparam logic [FIELD_W-1:0] FIXED_REST = FIELD_W'(6);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic                 header_ok;
		logic [HDR_LEN_W-1:0] header_length;
	} result_item_t;

endpackage

`default_nettype wire

/* hdl/gzip_member_header_parser.sv */
// Top level of the gzip member header parser: input register, per-byte
// header state update and result register.
// Depends on gzhp_pkg for the request structs and header constants.
`default_nettype none

// Takes one buffer byte per request, starting at a byte marked first_byte,
// and walks a gzip (RFC 1952) member header: magic, method, flags, the rest
// of the fixed part, then the optional extra field, name, comment and header
// CRC (skipped, not checked). One result per buffer: header_ok with the
// header length on the byte that completes the header, or an error on the
// first fault, on a truncated buffer, or on a length past the counter width.
// Later bytes are dropped until last_byte. The block takes one byte every
// cycle unless a stalled result holds it; a byte is held in the input register
// and its result is registered in the output register.
// A stall on the result side holds both registers and backs up into
// byte_stall in the same cycle.
module gzip_member_header_parser (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 byte_valid,
	output logic                      byte_stall,
	input  wire gzhp_pkg::byte_item_t byte_item,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output gzhp_pkg::result_item_t    result_item
);

	localparam int unsigned LB = gzhp_pkg::LENGTH_BITS;
	localparam int unsigned FW = gzhp_pkg::FIELD_W;

	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_ID1     = 4'd1;
	localparam logic [3:0] PH_ID2     = 4'd2;
	localparam logic [3:0] PH_CM      = 4'd3;
	localparam logic [3:0] PH_FLG     = 4'd4;
	localparam logic [3:0] PH_FIXED   = 4'd5;
	localparam logic [3:0] PH_XLO     = 4'd6;
	localparam logic [3:0] PH_XHI     = 4'd7;
	localparam logic [3:0] PH_EXTRA   = 4'd8;
	localparam logic [3:0] PH_NAME    = 4'd9;
	localparam logic [3:0] PH_COMMENT = 4'd10;
	localparam logic [3:0] PH_HCRC1   = 4'd11;
	localparam logic [3:0] PH_HCRC2   = 4'd12;
	localparam logic [3:0] PH_WAIT    = 4'd13;

	// Input register
	logic                 valid_s1;
	gzhp_pkg::byte_item_t item_s1;

	// Parser state
	logic [3:0]                  phase_q;
	logic [gzhp_pkg::FLAG_W-1:0] flags_q;
	logic [FW-1:0]               field_cnt_q;
	logic [7:0]                  xlo_q;
	logic [LB-1:0]               len_q;

	// Next-state and result logic
	logic [3:0]                  ph_cur, ph_nxt;
	logic [gzhp_pkg::FLAG_W-1:0] flags_cur, flags_nxt;
	logic [FW-1:0]               field_cur, field_nxt, field_dec, xlen;
	logic [7:0]                  xlo_cur, xlo_nxt;
	logic [LB-1:0]               len_cur, len_nxt;
	logic                        fail, emit;
	gzhp_pkg::result_item_t      res;

	logic out_blocked, advance_s1, accept_in;

	// First optional section at or after the given phase whose flag is set
	function automatic logic [3:0] next_section(
		input logic [3:0]                  from,
		input logic [gzhp_pkg::FLAG_W-1:0] flg
	);
		logic [3:0] r;
		r = PH_WAIT;
		if (from <= PH_HCRC1 && flg[gzhp_pkg::FLG_HCRC_BIT])       r = PH_HCRC1;
		if (from <= PH_COMMENT && flg[gzhp_pkg::FLG_COMMENT_BIT]) r = PH_COMMENT;
		if (from <= PH_NAME && flg[gzhp_pkg::FLG_NAME_BIT])       r = PH_NAME;
		if (from <= PH_XLO && flg[gzhp_pkg::FLG_EXTRA_BIT])       r = PH_XLO;
		return r;
	endfunction

	// Handshake: stage 1 moves on unless a result sits stalled at the output
	assign out_blocked = result_valid && result_stall;
	assign advance_s1  = valid_s1 && !out_blocked;
	assign byte_stall  = valid_s1 && out_blocked;
	assign accept_in   = byte_valid && !byte_stall;

	// Per-byte header walk
	always_comb begin
		// a first byte restarts from a cleared state
		if (item_s1.first_byte) begin
			ph_cur    = PH_ID1;
			flags_cur = '0;
			field_cur = '0;
			xlo_cur   = '0;
			len_cur   = '0;
		end else begin
			ph_cur    = phase_q;
			flags_cur = flags_q;
			field_cur = field_cnt_q;
			xlo_cur   = xlo_q;
			len_cur   = len_q;
		end

		ph_nxt    = ph_cur;
		flags_nxt = flags_cur;
		field_nxt = field_cur;
		xlo_nxt   = xlo_cur;
		len_nxt   = len_cur;
		fail      = 1'b0;
		emit      = 1'b0;
		field_dec = field_cur - FW'(1);
		xlen      = {item_s1.data_byte, xlo_cur};
		res       = '0;

		if (ph_cur == PH_IDLE || ph_cur > PH_WAIT) begin
			ph_nxt = PH_IDLE;
		end else if (ph_cur == PH_WAIT) begin
			if (item_s1.last_byte) begin
				ph_nxt = PH_IDLE;
			end
		end else begin
			if (&len_cur) begin
				fail = 1'b1;
			end else begin
				len_nxt = len_cur + LB'(1);
				unique case (ph_cur)
					PH_ID1: begin
						if (item_s1.data_byte != gzhp_pkg::MAGIC_ID1) fail = 1'b1;
						else ph_nxt = PH_ID2;
					end
					PH_ID2: begin
						if (item_s1.data_byte != gzhp_pkg::MAGIC_ID2) fail = 1'b1;
						else ph_nxt = PH_CM;
					end
					PH_CM: begin
						if (item_s1.data_byte != gzhp_pkg::METHOD_DEFL) fail = 1'b1;
						else ph_nxt = PH_FLG;
					end
					PH_FLG: begin
						if ((item_s1.data_byte & gzhp_pkg::FLG_RSVD) != 8'h00) begin
							fail = 1'b1;
						end else begin
							flags_nxt = item_s1.data_byte[gzhp_pkg::FLAG_W-1:0];
							field_nxt = gzhp_pkg::FIXED_REST;
							ph_nxt    = PH_FIXED;
						end
					end
					PH_FIXED: begin
						field_nxt = field_dec;
						if (field_dec == '0) ph_nxt = next_section(PH_XLO, flags_cur);
					end
					PH_XLO: begin
						xlo_nxt = item_s1.data_byte;
						ph_nxt  = PH_XHI;
					end
					PH_XHI: begin
						field_nxt = xlen;
						ph_nxt    = (xlen != '0) ? PH_EXTRA
							: next_section(PH_NAME, flags_cur);
					end
					PH_EXTRA: begin
						field_nxt = field_dec;
						if (field_dec == '0) ph_nxt = next_section(PH_NAME, flags_cur);
					end
					PH_NAME: begin
						if (item_s1.data_byte == 8'h00) begin
							ph_nxt = next_section(PH_COMMENT, flags_cur);
						end
					end
					PH_COMMENT: begin
						if (item_s1.data_byte == 8'h00) begin
							ph_nxt = next_section(PH_HCRC1, flags_cur);
						end
					end
					PH_HCRC1: ph_nxt = PH_HCRC2;
					PH_HCRC2: ph_nxt = PH_WAIT;
					default:  fail = 1'b1;
				endcase
			end

			// result on fault, on completion, or on running out of bytes
			if (fail) begin
				emit = 1'b1;
			end else if (ph_nxt == PH_WAIT) begin
				emit              = 1'b1;
				res.header_ok     = 1'b1;
				res.header_length = gzhp_pkg::HDR_LEN_W'(len_nxt);
			end else if (item_s1.last_byte) begin
				emit = 1'b1;
			end
			if (emit) begin
				ph_nxt = item_s1.last_byte ? PH_IDLE : PH_WAIT;
			end
		end
	end

	// Input register: load on accept, drop when consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			item_s1 <= byte_item;
		end
	end

	// Parser state: advance once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			flags_q     <= '0;
			field_cnt_q <= '0;
			xlo_q       <= '0;
			len_q       <= '0;
		end else if (advance_s1) begin
			phase_q     <= ph_nxt;
			flags_q     <= flags_nxt;
			field_cnt_q <= field_nxt;
			xlo_q       <= xlo_nxt;
			len_q       <= len_nxt;
		end
	end

	// Result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance_s1 && emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && emit) begin
			result_item <= res;
		end
	end

endmodule

`default_nettype wire

/* tb/gzhp_checker.sv */
// Checker for the gzip member header parser: watches the byte and result
// channels, predicts each header result and compares it field by field.
// Depends on gzhp_pkg for the request structs, widths and header byte codes.
`default_nettype none

module gzhp_checker
	import gzhp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         byte_valid,
	input  wire logic         byte_stall,
	input  wire byte_item_t   byte_item,
	input  wire logic         result_valid,
	input  wire logic         result_stall,
	input  wire result_item_t result_item,
	output int unsigned       mismatches,
	output int unsigned       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Where the parser stands within a header
	typedef enum logic [3:0] {
		AT_IDLE,
		AT_ID1,
		AT_ID2,
		AT_METHOD,
		AT_FLAGS,
		AT_FIXED,
		AT_XLEN_LO,
		AT_XLEN_HI,
		AT_EXTRA,
		AT_NAME,
		AT_COMMENT,
		AT_CRC_LO,
		AT_CRC_HI,
		AT_DONE
	} parse_at_e;

	parse_at_e              parse_at;
	logic [FLAG_W-1:0]      flags_kept;
	logic [FIELD_W-1:0]     skip_count;
	logic [7:0]             xlen_low;
	logic [LENGTH_BITS-1:0] bytes_seen;

	result_item_t expected_headers[$];

	initial begin
		mismatches = 0;
		pending = 0;
	end

	function automatic void clear_parser();
		parse_at = AT_IDLE;
		flags_kept = '0;
		skip_count = '0;
		xlen_low = '0;
		bytes_seen = '0;
	endfunction

	// First optional section at or after 'from' whose flag is set
	function automatic parse_at_e optional_after(input parse_at_e from);
		if (from <= AT_XLEN_LO && flags_kept[FLG_EXTRA_BIT])
			return AT_XLEN_LO;
		if (from <= AT_NAME && flags_kept[FLG_NAME_BIT])
			return AT_NAME;
		if (from <= AT_COMMENT && flags_kept[FLG_COMMENT_BIT])
			return AT_COMMENT;
		if (from <= AT_CRC_LO && flags_kept[FLG_HCRC_BIT])
			return AT_CRC_LO;
		return AT_DONE;
	endfunction

	// Advance the header walk by one byte; return 1 when it yields a result
	function automatic bit advance_header(input byte_item_t it, output result_item_t res);
		logic [7:0] b;
		bit         fail;
		b = it.data_byte;
		fail = 1'b0;
		res = '0;
		if (it.first_byte) begin
			clear_parser();
			parse_at = AT_ID1;
		end
		if (parse_at == AT_IDLE)
			return 1'b0;
		if (parse_at == AT_DONE) begin
			if (it.last_byte)
				parse_at = AT_IDLE;
			return 1'b0;
		end

		if (bytes_seen == '1) begin
			fail = 1'b1;
		end else begin
			bytes_seen = bytes_seen + 1'b1;
			case (parse_at)
				AT_ID1: begin
					if (b != MAGIC_ID1) fail = 1'b1;
					else parse_at = AT_ID2;
				end
				AT_ID2: begin
					if (b != MAGIC_ID2) fail = 1'b1;
					else parse_at = AT_METHOD;
				end
				AT_METHOD: begin
					if (b != METHOD_DEFL) fail = 1'b1;
					else parse_at = AT_FLAGS;
				end
				AT_FLAGS: begin
					if ((b & FLG_RSVD) != 8'h00) begin
						fail = 1'b1;
					end else begin
						flags_kept = b[FLAG_W-1:0];
						skip_count = FIXED_REST;
						parse_at = AT_FIXED;
					end
				end
				AT_FIXED: begin
					skip_count = skip_count - 1'b1;
					if (skip_count == '0)
						parse_at = optional_after(AT_XLEN_LO);
				end
				AT_XLEN_LO: begin
					xlen_low = b;
					parse_at = AT_XLEN_HI;
				end
				AT_XLEN_HI: begin
					skip_count = {b, xlen_low};
					parse_at = (skip_count != '0) ? AT_EXTRA : optional_after(AT_NAME);
				end
				AT_EXTRA: begin
					skip_count = skip_count - 1'b1;
					if (skip_count == '0)
						parse_at = optional_after(AT_NAME);
				end
				AT_NAME: begin
					if (b == 8'h00)
						parse_at = optional_after(AT_COMMENT);
				end
				AT_COMMENT: begin
					if (b == 8'h00)
						parse_at = optional_after(AT_CRC_LO);
				end
				AT_CRC_LO: parse_at = AT_CRC_HI;
				AT_CRC_HI: parse_at = AT_DONE;
				default: fail = 1'b1;
			endcase
		end

		if (fail) begin
			res = '0;
		end else if (parse_at == AT_DONE) begin
			res.header_ok = 1'b1;
			res.header_length = HDR_LEN_W'(bytes_seen);
		end else if (!it.last_byte) begin
			return 1'b0;
		end
		parse_at = it.last_byte ? AT_IDLE : AT_DONE;
		return 1'b1;
	endfunction

	// Compare delivered results first, then predict from the accepted byte
	always @(posedge clk or negedge arst_n) begin : watch
		result_item_t predicted;
		result_item_t oldest;
		if (!arst_n) begin
			clear_parser();
			expected_headers.delete();
			pending = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_headers.size() == 0) begin
					$display("%0t: header result with none predicted: expected none, got ok=%0b length=%0d",
						$time, result_item.header_ok, result_item.header_length);
					mismatches++;
				end else begin
					oldest = expected_headers.pop_front();
					if (result_item.header_ok !== oldest.header_ok) begin
						$display("%0t: header_ok differs: expected %0b, got %0b",
							$time, oldest.header_ok, result_item.header_ok);
						mismatches++;
					end
					if (result_item.header_length !== oldest.header_length) begin
						$display("%0t: header_length differs: expected %0d, got %0d",
							$time, oldest.header_length, result_item.header_length);
						mismatches++;
					end
				end
			end
			if (byte_valid && !byte_stall) begin
				if (advance_header(byte_item, predicted))
					expected_headers.push_back(predicted);
			end
			pending = expected_headers.size();
		end
	end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Top of the gzip member header parser testbench: clock, reset, byte and
// stall stimulus, and the final verdict from the header checker.
// Depends on gzhp_pkg, gzip_member_header_parser and gzhp_checker.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import gzhp_pkg::*;

	localparam int unsigned RANDOM_ITEMS  = 1650;
	localparam int unsigned SETTLE_CYCLES = 10;
	localparam int unsigned TIMEOUT_NS    = 10_000_000;

	typedef logic [7:0] octet_q_t[$];

	logic         clk          = 1'b0;
	logic         arst_n       = 1'b0;
	logic         byte_valid   = 1'b0;
	byte_item_t   byte_item    = '0;
	logic         result_stall = 1'b0;
	logic         byte_stall;
	logic         result_valid;
	result_item_t result_item;
	int unsigned  mismatches;
	int unsigned  pending;

	int unsigned  send_idle_pct  = 0;
	int unsigned  recv_stall_pct = 0;
	byte_item_t   buffer_bytes[$];

	always #1 clk = ~clk;

	gzip_member_header_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_item    (byte_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	gzhp_checker header_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_item    (byte_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	// Stall the result channel at the current rate
	always @(negedge clk) begin
		result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Offer one byte request after a random idle gap and hold it until taken
	task automatic push_byte(input logic [7:0] data, input logic is_first, input logic is_last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= '{data_byte: data, first_byte: is_first, last_byte: is_last};
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid and hold off until every predicted result has come back
	task automatic wait_for_results();
		byte_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	task automatic send_buffer();
		foreach (buffer_bytes[i])
			push_byte(buffer_bytes[i].data_byte, buffer_bytes[i].first_byte,
				buffer_bytes[i].last_byte);
	endtask

	task automatic add_octet(input logic [7:0] data);
		buffer_bytes.push_back('{data_byte: data, first_byte: 1'b0, last_byte: 1'b0});
	endtask

	// Send a short buffer, last byte marked, first byte marked when it starts a header
	task automatic send_directed(input octet_q_t octets, input bit starts);
		buffer_bytes.delete();
		foreach (octets[i])
			add_octet(octets[i]);
		buffer_bytes[0].first_byte = starts;
		buffer_bytes[buffer_bytes.size() - 1].last_byte = 1'b1;
		send_buffer();
	endtask

	task automatic add_string();
		repeat ($urandom_range(0, 6))
			add_octet(8'($urandom_range(1, 255)));
		add_octet(8'h00);
	endtask

	// Build one buffer: mostly a well-formed header with random content,
	// sometimes broken, cut short, restarted or preceded by stray bytes
	task automatic build_random_buffer(output int unsigned counted);
		int unsigned       kind;
		int unsigned       cut;
		int unsigned       xpick;
		int unsigned       pos;
		logic [FLAG_W-1:0] flg;
		logic [15:0]       xlen;
		kind = $urandom_range(0, 99);
		flg = FLAG_W'($urandom);
		buffer_bytes.delete();
		add_octet(MAGIC_ID1);
		add_octet(MAGIC_ID2);
		add_octet(METHOD_DEFL);
		add_octet({3'b000, flg});
		repeat (6)
			add_octet(8'($urandom));
		if (flg[FLG_EXTRA_BIT]) begin
			xpick = $urandom_range(0, 9);
			if (xpick == 0)
				xlen = '0;
			else if (xpick < 7)
				xlen = 16'($urandom_range(1, 6));
			else if (xpick == 7)
				xlen = 16'($urandom_range(7, 40));
			else if (xpick == 8)
				xlen = 16'($urandom_range(256, 65534));
			else
				xlen = 16'hFFFF;
			add_octet(xlen[7:0]);
			add_octet(xlen[15:8]);
			// long extra fields are only started; the buffer ends inside them
			repeat ((xlen > 48) ? 48 : xlen)
				add_octet(8'($urandom));
		end
		if (flg[FLG_NAME_BIT])
			add_string();
		if (flg[FLG_COMMENT_BIT])
			add_string();
		if (flg[FLG_HCRC_BIT])
			repeat (2)
				add_octet(8'($urandom));
		buffer_bytes[0].first_byte = 1'b1;

		if (kind < 10) begin
			// corrupt one of the leading fixed bytes
			pos = $urandom_range(0, 3);
			buffer_bytes[pos].data_byte ^= 8'($urandom_range(1, 255));
		end else if (kind < 15) begin
			// set reserved flag bits
			buffer_bytes[3].data_byte[7:5] = 3'($urandom_range(1, 7));
		end else if (kind < 30) begin
			// truncate before the header completes
			cut = $urandom_range(1, buffer_bytes.size() - 1);
			buffer_bytes = buffer_bytes[0:cut-1];
		end else if (kind < 38) begin
			// abandon a partial header and restart
			cut = $urandom_range(1, buffer_bytes.size() - 1);
			buffer_bytes = {buffer_bytes[0:cut-1], buffer_bytes};
		end
		counted = buffer_bytes.size();

		repeat ($urandom_range(0, 3))
			add_octet(8'($urandom));
		buffer_bytes[buffer_bytes.size() - 1].last_byte = 1'b1;
		if (kind >= 38 && kind < 44) begin
			// stray bytes while idle
			repeat ($urandom_range(1, 3))
				buffer_bytes.push_front('{data_byte: 8'($urandom), first_byte: 1'b0,
					last_byte: 1'($urandom)});
		end
	endtask

	// Stimulus and verdict
	initial begin
		int unsigned phase_idx;
		int unsigned counted;
		int unsigned items_sent;
		items_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: ignored bytes, minimal header ending on the last byte,
		// one-byte buffer, bad magic, bad method, reserved flags
		send_directed({8'hFF, 8'h00}, 1'b0);
		send_directed({MAGIC_ID1, MAGIC_ID2, METHOD_DEFL, 8'h00, 8'hFF,
			8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE}, 1'b1);
		send_directed({MAGIC_ID1}, 1'b1);
		send_directed({8'hE0}, 1'b1);
		send_directed({MAGIC_ID1, 8'h8A}, 1'b1);
		send_directed({MAGIC_ID1, MAGIC_ID2, 8'h09}, 1'b1);
		send_directed({MAGIC_ID1, MAGIC_ID2, METHOD_DEFL, FLG_RSVD}, 1'b1);
		wait_for_results();

		// Random buffers in four pacing phases
		for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
			case (phase_idx)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 84;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 84;
				end
				default: begin
					send_idle_pct = 16;
					recv_stall_pct = 16;
				end
			endcase
			while (items_sent < (phase_idx + 1) * RANDOM_ITEMS / 4) begin
				build_random_buffer(counted);
				send_buffer();
				items_sent += counted;
			end
			wait_for_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Give up on a hung run
	initial begin
		#(TIMEOUT_NS);
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
